>>> hdl/ntcth_pkg.sv
package ntcth_pkg;

  localparam int TABLE_ENTRIES = 80;
  localparam int ADC_BITS      = 10;
  localparam int TABLE_STORED  = 80;
  localparam int TABLE_SCAN    = (TABLE_ENTRIES < TABLE_STORED) ? TABLE_ENTRIES : TABLE_STORED;

  localparam int OP_W       = 2;
  localparam int SAMPLE_W   = 10;
  localparam int RES_W      = 19;
  localparam int TEMP_W     = 7;
  localparam int DUTY_W     = 8;
  localparam int HYST_W     = 4;
  localparam int VOLT_W     = 9;
  localparam int TBL_W      = 14;
  localparam int TBL_IDX_W  = $clog2(TABLE_STORED);
  localparam int DIV_CNT_W  = $clog2(RES_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SCALE_W    = 10;
  localparam int VPROD_W    = ADC_BITS + 1 + VOLT_W;
  localparam int SPROD_W    = ADC_BITS + 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = CFG_IDX_W'(1);

  localparam logic [DUTY_W-1:0]  PERIOD_RESET = DUTY_W'(255);
  localparam logic [HYST_W-1:0]  HYST_RESET   = HYST_W'(2);
  localparam logic [DUTY_W-1:0]  DUTY_TOP     = '1;
  localparam logic [RES_W-1:0]   R_MAX        = '1;
  localparam logic [VOLT_W-1:0]  VOLT_FULL    = VOLT_W'(500);
  localparam logic [SCALE_W-1:0] R_SCALE      = SCALE_W'(1000);
  localparam logic [3:0]         SP_SCALE     = 4'd10;
  localparam logic [TEMP_W-1:0]  TEMP_NONE    = TEMP_W'(TABLE_ENTRIES);

  typedef enum logic [OP_W-1:0] {
    OP_NTC  = 2'd0,
    OP_POT  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EXEC,
    ST_VOLT,
    ST_NUM,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    logic [RES_W-1:0]  resistance;
    logic [TEMP_W-1:0] temp;
    logic [TEMP_W-1:0] setpoint;
    logic [DUTY_W-1:0] duty;
    logic              ramp_down;
    logic              ramp_enable;
    logic              alarm;
    logic              open;
  } ntc_state_t;

  localparam int STATE_W = $bits(ntc_state_t);

  localparam ntc_state_t STATE_RESET = '{
    resistance:  '0,
    temp:        '0,
    setpoint:    '0,
    duty:        '0,
    ramp_down:   1'b0,
    ramp_enable: 1'b1,
    alarm:       1'b0,
    open:        1'b0
  };

  // thermistor resistance per degree, 10 ohm units, descending
  localparam logic [TBL_W-1:0] RT_TABLE [TABLE_STORED] = '{
    14'd9712, 14'd9166, 14'd8654, 14'd8172, 14'd7722, 14'd7298, 14'd6900, 14'd6526,
    14'd6176, 14'd5534, 14'd5242, 14'd4966, 14'd4708, 14'd4464, 14'd4234, 14'd4016,
    14'd3812, 14'd3620, 14'd3438, 14'd3266, 14'd3104, 14'd2950, 14'd2806, 14'd2668,
    14'd2540, 14'd2418, 14'd2302, 14'd2192, 14'd2088, 14'd1990, 14'd1897, 14'd1809,
    14'd1726, 14'd1646, 14'd1571, 14'd1500, 14'd1432, 14'd1368, 14'd1307, 14'd1249,
    14'd1194, 14'd1142, 14'd1092, 14'd1045, 14'd1000, 14'd957,  14'd916,  14'd877,
    14'd840,  14'd805,  14'd772,  14'd740,  14'd709,  14'd680,  14'd653,  14'd626,
    14'd601,  14'd577,  14'd554,  14'd532,  14'd511,  14'd491,  14'd472,  14'd454,
    14'd436,  14'd420,  14'd404,  14'd388,  14'd374,  14'd360,  14'd346,  14'd334,
    14'd321,  14'd309,  14'd298,  14'd287,  14'd277,  14'd267,  14'd258,  14'd248
  };

endpackage

>>> hdl/ntcth_in_if.sv
interface ntcth_in_if;
  logic                              valid;
  logic                              ready;
  logic [ntcth_pkg::OP_W-1:0]        op;
  logic [ntcth_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

>>> hdl/ntcth_out_if.sv
interface ntcth_out_if;
  logic                           valid;
  logic                           ready;
  logic                           alarm;
  logic [ntcth_pkg::DUTY_W-1:0]   duty;
  logic                           breathing;
  logic [ntcth_pkg::TEMP_W-1:0]   temperature;
  logic [ntcth_pkg::TEMP_W-1:0]   setpoint_out;
  logic [ntcth_pkg::RES_W-1:0]    resistance;
  logic                           sensor_open;

  modport source (output valid, output alarm, output duty, output breathing,
                  output temperature, output setpoint_out, output resistance,
                  output sensor_open, input ready);
  modport sink   (input valid, input alarm, input duty, input breathing,
                  input temperature, input setpoint_out, input resistance,
                  input sensor_open, output ready);
endinterface

>>> hdl/ntcth_ram.sv
module ntcth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ntc_thermostat_with_breathing_pwm_core.sv
// ntc thermostat with breathing pwm lamp
// input channel in_ch carries one beat per item: op selects an ntc sample,
// a setpoint pot sample or a pwm ramp tick, and op 3 is a no-op; sample is the adc reading.
// every input beat gives exactly one result beat on out_ch with the alarm,
// duty, breathing, temperature, setpoint, resistance and open-sensor state
// as it stands after that item.
// cfg_we/cfg_index/cfg_wdata write pwm_period (index 0) and hysteresis
// (index 1); other indexes are dropped. write only while the block is idle.
// one item is in work at a time; the state word lives in a single-entry
// synchronous ram that is read, updated and written back per item.
// each item goes from idle to load; pot, tick and unused op then pass exec and done;
// an ntc sample passes volt, num, 19 bit-serial divider steps (skipped when the
// sensor is open) and 1..80 table compares, one entry a cycle, then done.
// a new input beat is taken as soon as the previous item is written to the
// output register, even while that result waits for out_ch.ready; a stalled
// output holds the next finished item in its done state until taken.
// synchronous reset: output empty, state reads as its reset value (breathing
// on, duty 0, alarm off), pwm_period 255, hysteresis 2.
module ntc_thermostat_with_breathing_pwm_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ntcth_in_if.sink                             in_ch,
  ntcth_out_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [ntcth_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ntcth_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ntcth_pkg::fsm_t                         state_r, state_nxt;
  logic [ntcth_pkg::DUTY_W-1:0]            period_r;
  logic [ntcth_pkg::HYST_W-1:0]            hyst_r;
  logic                                    mem_valid_r, mem_valid_nxt;
  logic                                    out_valid_r, out_valid_nxt;

  ntcth_pkg::op_t                          op_r, op_nxt;
  logic [ntcth_pkg::ADC_BITS-1:0]          adc_r, adc_nxt;
  ntcth_pkg::ntc_state_t                   st_r, st_nxt;
  logic [ntcth_pkg::VOLT_W-1:0]            volt_r, volt_nxt;
  logic [ntcth_pkg::RES_W-1:0]             num_r, num_nxt;
  logic [ntcth_pkg::VOLT_W:0]              rem_r, rem_nxt;
  logic [ntcth_pkg::DIV_CNT_W-1:0]         div_cnt_r, div_cnt_nxt;
  logic [ntcth_pkg::TBL_IDX_W-1:0]         idx_r, idx_nxt;
  ntcth_pkg::ntc_state_t                   out_r, out_nxt;

  logic                                    ram_we;
  logic                                    ram_re;
  logic [ntcth_pkg::STATE_W-1:0]           ram_rdata;

  logic                                    in_fire;
  logic                                    out_load;
  logic [ntcth_pkg::ADC_BITS:0]            inv;
  logic [ntcth_pkg::VPROD_W-1:0]           vprod;
  logic [ntcth_pkg::VOLT_W-1:0]            vdiff;
  logic [ntcth_pkg::VOLT_W+ntcth_pkg::SCALE_W-1:0] nprod;
  logic [ntcth_pkg::VOLT_W:0]              rem_sh;
  logic                                    qbit;
  logic [ntcth_pkg::SPROD_W-1:0]           sprod;
  logic [ntcth_pkg::TEMP_W-1:0]            sp_new;
  logic [ntcth_pkg::TEMP_W:0]              sp_lim;
  logic                                    hit;

  assign in_ch.ready = (state_r == ntcth_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ntcth_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
  assign ram_we      = out_load;
  assign ram_re      = in_fire;

  ntcth_ram #(
    .WIDTH (ntcth_pkg::STATE_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (1'b0),
    .wdata (st_r),
    .re    (ram_re),
    .raddr (1'b0),
    .rdata (ram_rdata)
  );

  // datapath arithmetic
  always_comb begin
    inv    = (ntcth_pkg::ADC_BITS+1)'(1 << ntcth_pkg::ADC_BITS) - {1'b0, adc_r};
    vprod  = ntcth_pkg::VPROD_W'(inv) * ntcth_pkg::VPROD_W'(ntcth_pkg::VOLT_FULL);
    vdiff  = ntcth_pkg::VOLT_FULL - volt_r;
    nprod  = (ntcth_pkg::VOLT_W+ntcth_pkg::SCALE_W)'(vdiff) *
             (ntcth_pkg::VOLT_W+ntcth_pkg::SCALE_W)'(ntcth_pkg::R_SCALE);
    rem_sh = {rem_r[ntcth_pkg::VOLT_W-1:0], num_r[ntcth_pkg::RES_W-1]};
    qbit   = (rem_sh >= {1'b0, volt_r});
    sprod  = ntcth_pkg::SPROD_W'(adc_r) * ntcth_pkg::SPROD_W'(ntcth_pkg::SP_SCALE);
    sp_new = ntcth_pkg::TEMP_W'(sprod >> (ntcth_pkg::ADC_BITS - 3));
    sp_lim = {1'b0, st_r.temp} + (ntcth_pkg::TEMP_W+1)'(hyst_r);
    hit    = (st_r.resistance >= ntcth_pkg::RES_W'(ntcth_pkg::RT_TABLE[idx_r]));
  end

  always_comb begin
    state_nxt     = state_r;
    mem_valid_nxt = mem_valid_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    adc_nxt       = adc_r;
    st_nxt        = st_r;
    volt_nxt      = volt_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ntcth_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_nxt    = ntcth_pkg::op_t'(in_ch.op);
          adc_nxt   = ntcth_pkg::ADC_BITS'(in_ch.sample);
          state_nxt = ntcth_pkg::ST_LOAD;
        end
      end
      ntcth_pkg::ST_LOAD: begin
        st_nxt    = mem_valid_r ? ntcth_pkg::ntc_state_t'(ram_rdata) : ntcth_pkg::STATE_RESET;
        state_nxt = (op_r == ntcth_pkg::OP_NTC) ? ntcth_pkg::ST_VOLT : ntcth_pkg::ST_EXEC;
      end
      ntcth_pkg::ST_EXEC: begin
        unique case (op_r)
          ntcth_pkg::OP_POT: begin
            st_nxt.setpoint = sp_new;
            if (sp_lim <= {1'b0, sp_new}) begin
              st_nxt.alarm       = 1'b1;
              st_nxt.ramp_enable = 1'b0;
              st_nxt.duty        = period_r;
            end else if (st_r.temp > sp_new) begin
              st_nxt.alarm       = 1'b0;
              st_nxt.ramp_enable = 1'b1;
            end
          end
          ntcth_pkg::OP_TICK: begin
            if (st_r.ramp_enable) begin
              priority if (st_r.duty >= period_r) begin
                st_nxt.ramp_down = 1'b1;
              end else if (st_r.duty == '0) begin
                st_nxt.ramp_down = 1'b0;
              end
              if (st_nxt.ramp_down) begin
                if (st_r.duty != '0) begin
                  st_nxt.duty = st_r.duty - 1'b1;
                end
              end else if (st_r.duty != ntcth_pkg::DUTY_TOP) begin
                st_nxt.duty = st_r.duty + 1'b1;
              end
            end
          end
          ntcth_pkg::OP_NTC, ntcth_pkg::OP_NONE: begin
          end
        endcase
        state_nxt = ntcth_pkg::ST_DONE;
      end
      ntcth_pkg::ST_VOLT: begin
        volt_nxt  = ntcth_pkg::VOLT_W'(vprod >> ntcth_pkg::ADC_BITS);
        state_nxt = ntcth_pkg::ST_NUM;
      end
      ntcth_pkg::ST_NUM: begin
        idx_nxt = '0;
        if (volt_r == '0) begin
          st_nxt.resistance = ntcth_pkg::R_MAX;
          st_nxt.open       = 1'b1;
          state_nxt         = ntcth_pkg::ST_SCAN;
        end else begin
          num_nxt     = ntcth_pkg::RES_W'(nprod);
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = ntcth_pkg::ST_DIV;
        end
      end
      ntcth_pkg::ST_DIV: begin
        rem_nxt     = qbit ? (rem_sh - {1'b0, volt_r}) : rem_sh;
        num_nxt     = {num_r[ntcth_pkg::RES_W-2:0], qbit};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == ntcth_pkg::DIV_CNT_W'(ntcth_pkg::RES_W - 1)) begin
          st_nxt.resistance = {num_r[ntcth_pkg::RES_W-2:0], qbit};
          st_nxt.open       = 1'b0;
          state_nxt         = ntcth_pkg::ST_SCAN;
        end
      end
      ntcth_pkg::ST_SCAN: begin
        priority if (hit) begin
          st_nxt.temp = ntcth_pkg::TEMP_W'(idx_r);
          state_nxt   = ntcth_pkg::ST_DONE;
        end else if (idx_r == ntcth_pkg::TBL_IDX_W'(ntcth_pkg::TABLE_SCAN - 1)) begin
          st_nxt.temp = ntcth_pkg::TEMP_NONE;
          state_nxt   = ntcth_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ntcth_pkg::ST_DONE: begin
        if (out_load) begin
          out_nxt       = st_r;
          out_valid_nxt = 1'b1;
          mem_valid_nxt = 1'b1;
          state_nxt     = ntcth_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ntcth_pkg::ST_IDLE;
      mem_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mem_valid_r <= mem_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= ntcth_pkg::PERIOD_RESET;
      hyst_r   <= ntcth_pkg::HYST_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ntcth_pkg::CFG_PWM_PERIOD) begin
        period_r <= ntcth_pkg::DUTY_W'(cfg_wdata);
      end else if (cfg_index == ntcth_pkg::CFG_HYSTERESIS) begin
        hyst_r <= ntcth_pkg::HYST_W'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    adc_r     <= adc_nxt;
    st_r      <= st_nxt;
    volt_r    <= volt_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    idx_r     <= idx_nxt;
    out_r     <= out_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.alarm        = out_r.alarm;
  assign out_ch.duty         = out_r.duty;
  assign out_ch.breathing    = out_r.ramp_enable;
  assign out_ch.temperature  = out_r.temp;
  assign out_ch.setpoint_out = out_r.setpoint;
  assign out_ch.resistance   = out_r.resistance;
  assign out_ch.sensor_open  = out_r.open;

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ntcth_pkg::ST_LOAD))
    else $error("accepted beat did not start a state read");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ntcth_pkg::ST_DIV) |-> (div_cnt_r < ntcth_pkg::DIV_CNT_W'(ntcth_pkg::RES_W)))
    else $error("divider ran past its step count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ntcth_pkg::ST_SCAN) |->
      (idx_r < ntcth_pkg::TBL_IDX_W'(ntcth_pkg::TABLE_SCAN)))
    else $error("table scan index out of range");

  a_alarm_stops_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ch.alarm != out_ch.breathing))
    else $error("alarm and breathing both set or both clear");

endmodule

>>> verif/tb_ntc_thermostat_with_breathing_pwm_core.sv
module tb_ntc_thermostat_with_breathing_pwm_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ntcth_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 140;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE_END   = 120;

  typedef struct packed {
    logic              alarm;
    logic [DUTY_W-1:0] duty;
    logic              breathing;
    logic [TEMP_W-1:0] temperature;
    logic [TEMP_W-1:0] setpoint;
    logic [RES_W-1:0]  resistance;
    logic              sensor_open;
  } lamp_report_t;

  class thermostat_tracker;
    logic [DUTY_W-1:0] period;
    logic [HYST_W-1:0] hyst;
    lamp_report_t      now;
    logic              ramp_down;
    lamp_report_t      expected_reports[$];
    int                faults;

    function new();
      period         = 8'd255;
      hyst           = 4'd2;
      now            = '0;
      now.breathing  = 1'b1;
      ramp_down      = 1'b0;
      faults         = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PWM_PERIOD: period = data;
        CFG_HYSTERESIS: hyst = data[HYST_W-1:0];
        default: ;
      endcase
    endfunction

    // work out the lamp state after one accepted item
    function void take_item(op_t op, logic [SAMPLE_W-1:0] smp);
      int unsigned inv, volt, ohms, idx, scaled;
      case (op)
        OP_NTC: begin
          inv  = (1 << ADC_BITS) - smp;
          volt = (inv * 500) >> ADC_BITS;
          if (volt == 0) begin
            ohms = R_MAX;
            now.sensor_open = 1'b1;
          end else begin
            ohms = ((500 - volt) * 1000) / volt;
            if (ohms > R_MAX) ohms = R_MAX;
            now.sensor_open = 1'b0;
          end
          now.resistance = ohms[RES_W-1:0];
          idx = 0;
          while (idx < TABLE_SCAN && ohms < RT_TABLE[idx]) idx++;
          now.temperature = (idx == TABLE_SCAN) ? TEMP_NONE : idx[TEMP_W-1:0];
        end
        OP_POT: begin
          scaled = smp;
          scaled = (scaled * 10) >> (ADC_BITS - 3);
          now.setpoint = scaled[TEMP_W-1:0];
          if (int'(now.temperature) + int'(hyst) <= int'(now.setpoint)) begin
            now.alarm     = 1'b1;
            now.breathing = 1'b0;
            now.duty      = period;
          end else if (now.temperature > now.setpoint) begin
            now.alarm     = 1'b0;
            now.breathing = 1'b1;
          end
        end
        OP_TICK: begin
          if (now.breathing) begin
            if (now.duty >= period) ramp_down = 1'b1;
            else if (now.duty == '0) ramp_down = 1'b0;
            if (ramp_down) begin
              if (now.duty != '0) now.duty--;
            end else if (now.duty != DUTY_TOP) begin
              now.duty++;
            end
          end
        end
        default: ;
      endcase
      expected_reports.push_back(now);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        faults++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_report(lamp_report_t got);
      lamp_report_t want;
      if (expected_reports.size() == 0) begin
        faults++;
        $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
        return;
      end
      want = expected_reports.pop_front();
      compare_field("alarm", want.alarm, got.alarm);
      compare_field("duty", want.duty, got.duty);
      compare_field("breathing", want.breathing, got.breathing);
      compare_field("temperature", want.temperature, got.temperature);
      compare_field("setpoint_out", want.setpoint, got.setpoint);
      compare_field("resistance", want.resistance, got.resistance);
      compare_field("sensor_open", want.sensor_open, got.sensor_open);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ntcth_in_if  in_ch();
  ntcth_out_if out_ch();

  thermostat_tracker tracker = new();
  int idle_odds = 0;

  ntc_thermostat_with_breathing_pwm_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input op_t op, input logic [SAMPLE_W-1:0] smp);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_item(op, smp);
  endtask

  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(idx, data);
  endtask

  // result side: random stalls plus two long hold-offs to back up the block
  initial begin
    int hold;
    int taken;
    hold  = 0;
    taken = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_report('{alarm: out_ch.alarm, duty: out_ch.duty,
                               breathing: out_ch.breathing,
                               temperature: out_ch.temperature,
                               setpoint: out_ch.setpoint_out,
                               resistance: out_ch.resistance,
                               sensor_open: out_ch.sensor_open});
        taken++;
        if (taken == 300 || taken == 800) hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    op_t                 op;
    logic [SAMPLE_W-1:0] smp;
    int unsigned         pick;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_NTC;
    in_ch.sample = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: open sensor, alarm on and hold, thresholds, ramp turn, above range
    idle_odds = 4;
    send_item(OP_NTC, 10'h3FF);
    send_item(OP_POT, 10'h3FF);
    send_item(OP_TICK, 10'h000);
    send_item(OP_POT, 10'h000);
    send_item(OP_NTC, 10'h000);
    send_item(OP_POT, 10'h000);
    send_item(OP_TICK, 10'h3FF);
    send_item(OP_TICK, 10'h2AA);
    send_item(OP_NONE, 10'h3FF);
    send_item(OP_NTC, 10'd512);
    send_item(OP_NTC, 10'd1);
    send_item(OP_NTC, 10'h1FF);
    send_item(OP_POT, 10'd682);
    send_item(OP_NTC, 10'h2AA);
    send_item(OP_NTC, 10'h155);
    send_item(OP_POT, 10'h155);
    send_item(OP_TICK, 10'h155);
    send_item(OP_NONE, 10'h000);
    send_item(OP_NTC, 10'h3FE);
    send_item(OP_POT, 10'h2AA);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain(4);
      case (ph)
        0: begin
          write_reg(CFG_PWM_PERIOD, 8'd255);
          write_reg(CFG_HYSTERESIS, 8'd15);
        end
        1: begin
          write_reg(CFG_PWM_PERIOD, 8'd1);
          write_reg(CFG_HYSTERESIS, 8'd0);
        end
        2: begin
          write_reg(CFG_PWM_PERIOD, 8'd0);
          write_reg(CFG_HYSTERESIS, 8'd2);
          write_reg(CFG_SPARE_LO, 8'($urandom));
          write_reg(CFG_SPARE_HI, 8'($urandom));
        end
        3: begin
          write_reg(CFG_PWM_PERIOD, 8'd8);
          write_reg(CFG_HYSTERESIS, 8'hA5);
        end
        4: begin
          write_reg(CFG_PWM_PERIOD, 8'($urandom_range(2, 40)));
          write_reg(CFG_HYSTERESIS, 8'($urandom_range(0, 15)));
        end
        5: begin
          write_reg(CFG_PWM_PERIOD, 8'($urandom_range(1, 255)));
          write_reg(CFG_HYSTERESIS, 8'($urandom_range(0, 15)));
        end
        6: begin
          write_reg(CFG_PWM_PERIOD, 8'($urandom_range(20, 80)));
          write_reg(CFG_HYSTERESIS, 8'd0);
        end
        default: begin
          write_reg(CFG_PWM_PERIOD, 8'($urandom_range(1, 30)));
          write_reg(CFG_HYSTERESIS, 8'($urandom_range(0, 15)));
        end
      endcase
      idle_odds = (ph == 3 || ph == PHASES - 1) ? 0 : 4;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) op = OP_TICK;
        else if (pick < 70) op = OP_NTC;
        else if (pick < 95) op = OP_POT;
        else op = OP_NONE;
        case ($urandom_range(0, 9))
          0: smp = '0;
          1: smp = '1;
          2, 3, 4: smp = (op == OP_NTC) ? SAMPLE_W'($urandom_range(200, 900))
                                        : SAMPLE_W'($urandom);
          default: smp = SAMPLE_W'($urandom);
        endcase
        send_item(op, smp);
      end
    end

    drain(SETTLE_END);
    if (tracker.faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
hdl/ntcth_pkg.sv
hdl/ntcth_in_if.sv
hdl/ntcth_out_if.sv
hdl/ntcth_ram.sv
hdl/ntc_thermostat_with_breathing_pwm_core.sv
verif/tb_ntc_thermostat_with_breathing_pwm_core.sv
